// File: src/spm_pkg.sv
package spm_pkg;

  // Operand store capacity and exponent limits.
  localparam int MAX_TERMS = 16;
  localparam int MAX_EXP   = 15;
  localparam int EXP_CAP   = (MAX_EXP < 15) ? MAX_EXP : 15;
  localparam int SUM_SLOTS = 2 * EXP_CAP + 1;

  // Widths derived from the capacities.
  localparam int IDX_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);
  localparam int SADDR_W = $clog2(SUM_SLOTS);
  localparam int SCNT_W  = $clog2(SUM_SLOTS + 1);
  localparam int PROD_W  = 32;
  localparam int ACC_W   = ((PROD_W + $clog2(MAX_TERMS * MAX_TERMS)) > 40) ?
                           (PROD_W + $clog2(MAX_TERMS * MAX_TERMS)) : 40;
  localparam int COEF_W  = 40;

  // Item mode codes.
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_PROD   = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] term_coef;
    logic [3:0]         term_exponent;
  } item_t;

  typedef struct packed {
    logic [4:0]               prod_exponent;
    logic signed [COEF_W-1:0] prod_coef;
    logic                     last_term;
    logic                     empty_product;
    logic                     overflow_seen;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic issue;
    logic scan;
    logic emit_empty;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_empty;
    logic b_empty;
    logic last_pair;
    logic pipe_busy;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// File: src/spm_ctrl.sv
module spm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       item_mode,
  input  spm_pkg::status_t status,
  output spm_pkg::cmd_t    cmd,
  output logic             item_stall
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIRS,
    ST_DRAIN,
    ST_SCAN,
    ST_EMPTY,
    ST_CLEAR
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Items are taken only while idle.
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);

  // Command decode.
  always_comb begin
    cmd            = '0;
    cmd.load_a     = accept && (item_mode == spm_pkg::MODE_LOAD_A);
    cmd.load_b     = accept && (item_mode == spm_pkg::MODE_LOAD_B);
    cmd.issue      = (state == ST_PAIRS);
    cmd.scan       = (state == ST_SCAN);
    cmd.emit_empty = (state == ST_EMPTY) && status.out_free;
    cmd.clear      = (state == ST_CLEAR);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (item_mode == spm_pkg::MODE_PROD)) begin
          if (status.a_empty || status.b_empty) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_PAIRS;
          end
        end
      end
      ST_PAIRS: begin
        if (status.last_pair) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_CLEAR;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/spm_datapath.sv
module spm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  spm_pkg::item_t    item,
  input  spm_pkg::cmd_t     cmd,
  output spm_pkg::status_t  status,
  output logic              result_valid,
  input  logic              result_stall,
  output spm_pkg::result_t  result
);

  typedef struct packed {
    logic signed [15:0] coef;
    logic [3:0]         expo;
  } term_t;

  // Saturated value at the 40-bit signed range for the result field.
  function automatic logic signed [spm_pkg::COEF_W-1:0] sat_coef(
    input logic signed [spm_pkg::ACC_W-1:0] v
  );
    logic signed [spm_pkg::ACC_W-1:0] hi;
    logic signed [spm_pkg::ACC_W-1:0] lo;
    hi = spm_pkg::ACC_W'({1'b0, {(spm_pkg::COEF_W - 1){1'b1}}});
    lo = -hi - spm_pkg::ACC_W'(1);
    if (v > hi) begin
      sat_coef = hi[spm_pkg::COEF_W-1:0];
    end else if (v < lo) begin
      sat_coef = lo[spm_pkg::COEF_W-1:0];
    end else begin
      sat_coef = v[spm_pkg::COEF_W-1:0];
    end
  endfunction

  // Operand term stores and counts.
  term_t                      a_mem [spm_pkg::MAX_TERMS];
  term_t                      b_mem [spm_pkg::MAX_TERMS];
  logic [spm_pkg::CNT_W-1:0]  a_count;
  logic [spm_pkg::CNT_W-1:0]  b_count;
  logic                       dropped;

  // Pair walk and product pipeline.
  logic [spm_pkg::IDX_W-1:0]  pair_i;
  logic [spm_pkg::IDX_W-1:0]  pair_j;
  logic                       i_last;
  logic                       j_last;
  term_t                      a_rd;
  term_t                      b_rd;
  logic                       s1_valid;
  logic signed [spm_pkg::PROD_W-1:0] prod;
  logic [4:0]                 psum;
  logic                       s2_valid;

  // Accumulators; an unmarked slot reads as zero.
  logic signed [spm_pkg::ACC_W-1:0] acc_mem [spm_pkg::SUM_SLOTS];
  logic [spm_pkg::SUM_SLOTS-1:0]    mark;
  logic [spm_pkg::SADDR_W-1:0]      acc_addr;
  logic signed [spm_pkg::ACC_W-1:0] acc_rd;
  logic                             acc_en;

  // Ordered scan with a one-entry lookahead.
  logic [spm_pkg::SCNT_W-1:0]       scan_idx;
  logic                             at_end;
  logic                             hit;
  logic                             pend_valid;
  logic [spm_pkg::SADDR_W-1:0]      pend_addr;
  logic signed [spm_pkg::ACC_W-1:0] pend_coef;
  logic                             push;
  logic                             advance;
  logic                             out_free;
  logic                             load_drop_a;
  logic                             load_drop_b;

  assign out_free = !result_valid || !result_stall;

  // A term is dropped when its exponent is too large or the store is full.
  assign load_drop_a = (32'(item.term_exponent) > spm_pkg::EXP_CAP) ||
                       (32'(a_count) >= spm_pkg::MAX_TERMS);
  assign load_drop_b = (32'(item.term_exponent) > spm_pkg::EXP_CAP) ||
                       (32'(b_count) >= spm_pkg::MAX_TERMS);

  // Term store writes.
  always_ff @(posedge clk) begin
    if (cmd.load_a && !load_drop_a) begin
      a_mem[a_count[spm_pkg::IDX_W-1:0]] <= '{coef: item.term_coef,
                                              expo: item.term_exponent};
    end
    if (cmd.load_b && !load_drop_b) begin
      b_mem[b_count[spm_pkg::IDX_W-1:0]] <= '{coef: item.term_coef,
                                              expo: item.term_exponent};
    end
  end

  // Counts and the dropped flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      a_count <= '0;
      b_count <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.load_a) begin
        if (load_drop_a) begin
          dropped <= 1'b1;
        end else begin
          a_count <= a_count + 1'b1;
        end
      end
      if (cmd.load_b) begin
        if (load_drop_b) begin
          dropped <= 1'b1;
        end else begin
          b_count <= b_count + 1'b1;
        end
      end
    end
  end

  // Pair walk: j runs fastest over B, i over A.
  assign i_last = (spm_pkg::CNT_W'(pair_i) + 1'b1) == a_count;
  assign j_last = (spm_pkg::CNT_W'(pair_j) + 1'b1) == b_count;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pair_i <= '0;
      pair_j <= '0;
    end else if (cmd.issue) begin
      if (j_last) begin
        pair_j <= '0;
        pair_i <= pair_i + 1'b1;
      end else begin
        pair_j <= pair_j + 1'b1;
      end
    end
  end

  // Term reads, then product and exponent sum.
  always_ff @(posedge clk) begin
    a_rd <= a_mem[pair_i];
    b_rd <= b_mem[pair_j];
    prod <= a_rd.coef * b_rd.coef;
    psum <= 5'(a_rd.expo) + 5'(b_rd.expo);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  // Accumulator read address: product slot while accumulating, scan slot after.
  assign acc_addr = cmd.scan ? scan_idx[spm_pkg::SADDR_W-1:0] :
                               spm_pkg::SADDR_W'(psum);
  assign acc_rd   = mark[acc_addr] ? acc_mem[acc_addr] : '0;
  assign acc_en   = s2_valid && (32'(psum) < spm_pkg::SUM_SLOTS);

  always_ff @(posedge clk) begin
    if (acc_en) begin
      acc_mem[acc_addr] <= acc_rd + spm_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mark <= '0;
    end else if (acc_en) begin
      mark[acc_addr] <= 1'b1;
    end
  end

  // Scan step: a pending term leaves when the next one is found or at the end.
  assign at_end  = (32'(scan_idx) == spm_pkg::SUM_SLOTS);
  assign hit     = !at_end && mark[acc_addr];
  assign push    = cmd.scan && pend_valid && (hit || at_end) && out_free;
  assign advance = cmd.scan && !at_end && (!hit || !pend_valid || out_free);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      scan_idx   <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (advance) begin
        scan_idx <= scan_idx + 1'b1;
        if (hit) begin
          pend_valid <= 1'b1;
        end
      end else if (push && at_end) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      pend_addr <= acc_addr;
      pend_coef <= acc_rd;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push || cmd.emit_empty) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      result.prod_exponent <= '0;
      result.prod_coef     <= '0;
      result.last_term     <= 1'b1;
      result.empty_product <= 1'b1;
      result.overflow_seen <= dropped;
    end else if (push) begin
      result.prod_exponent <= 5'(pend_addr);
      result.prod_coef     <= sat_coef(pend_coef);
      result.last_term     <= at_end;
      result.empty_product <= 1'b0;
      result.overflow_seen <= dropped;
    end
  end

  // Status to the controller.
  always_comb begin
    status           = '0;
    status.a_empty   = (a_count == '0);
    status.b_empty   = (b_count == '0);
    status.last_pair = cmd.issue && i_last && j_last;
    status.pipe_busy = s1_valid || s2_valid;
    status.scan_done = cmd.scan && at_end && (!pend_valid || out_free);
    status.out_free  = out_free;
  end

  // Checks on the datapath.
  a_scan_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !s1_valid && !s2_valid)
    else $error("scan started with products still in flight");

  a_clear_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (mark == '0) && !pend_valid && (a_count == '0) && (b_count == '0))
    else $error("stores not cleared after a run");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.empty_product || result.last_term))
    else $error("empty result not flagged as last");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    cmd.load_a && (32'(a_count) >= spm_pkg::MAX_TERMS) |=> dropped)
    else $error("term beyond capacity not flagged");

  a_no_load_in_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue || cmd.scan) |-> !cmd.load_a && !cmd.load_b)
    else $error("term loaded during a product run");

endmodule

// File: src/sparse_polynomial_multiplier.sv
// Term loads (modes A and B) are taken while the block is idle, one per cycle.
// A product request walks every term pair, one pair per cycle through a
// term read, a multiply and an accumulate stage, then scans the 31
// exponent slots in order.
// Sync reset clears counts, present marks, the dropped flag and the output;
// a run clears all of it but the output after its last result.
module sparse_polynomial_multiplier (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  spm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output spm_pkg::result_t result
);

  spm_pkg::cmd_t    cmd;
  spm_pkg::status_t status;

  spm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_mode  (item.mode),
    .status     (status),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  spm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: dv/tb_sparse_polynomial_multiplier.sv
`timescale 1ns / 100ps

module tb_sparse_polynomial_multiplier;

  // Unused mode code; the block takes the beat and ignores it.
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 60;
  localparam longint COEF_HI  = 64'sd549755813887;
  localparam longint COEF_LO  = -64'sd549755813888;

  // One row of the directed table: a beat, how often it repeats, and an optional
  // hand-written product term that replaces the predicted one.
  typedef struct packed {
    spm_pkg::item_t   beat;
    logic [7:0]       reps;
    logic             typed;
    spm_pkg::result_t want;
  } dir_row_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  spm_pkg::item_t   item         = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  spm_pkg::result_t result;

  // Side channel that travels with the item payload.
  logic             row_typed = 1'b0;
  spm_pkg::result_t row_want  = '0;

  // Operand stores of the predictor.
  logic signed [15:0] a_coef [spm_pkg::MAX_TERMS];
  logic [3:0]         a_exp  [spm_pkg::MAX_TERMS];
  logic signed [15:0] b_coef [spm_pkg::MAX_TERMS];
  logic [3:0]         b_exp  [spm_pkg::MAX_TERMS];
  int                 a_len;
  int                 b_len;
  bit                 drop_seen;

  spm_pkg::result_t pending_terms[$];
  spm_pkg::result_t fresh_terms[$];
  spm_pkg::result_t want;
  dir_row_t         dir_rows[$];

  int  err_count   = 0;
  int  n_items     = 0;
  int  n_products  = 0;
  int  n_empty     = 0;
  int  n_results   = 0;
  int  n_sent      = 0;
  int  n_seq       = 0;
  int  idle_cycles = 0;
  int  stall_left  = 0;
  int  cyc         = 0;
  int  roll;
  int  stall_len;
  bit  steady      = 1'b0;

  sparse_polynomial_multiplier u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_operands();
    a_len     = 0;
    b_len     = 0;
    drop_seen = 1'b0;
  endfunction

  // Store a term, or drop it when the exponent is out of range or the store is full.
  function automatic void take_term(bit to_b, logic signed [15:0] c, logic [3:0] e);
    if (int'(e) > spm_pkg::EXP_CAP || (to_b ? b_len : a_len) >= spm_pkg::MAX_TERMS) begin
      drop_seen = 1'b1;
    end else if (to_b) begin
      b_coef[b_len] = c;
      b_exp[b_len]  = e;
      b_len++;
    end else begin
      a_coef[a_len] = c;
      a_exp[a_len]  = e;
      a_len++;
    end
  endfunction

  // Multiply A by B into fresh_terms, in ascending exponent order, then clear.
  function automatic void multiply_operands();
    longint           acc [spm_pkg::SUM_SLOTS];
    bit               hit [spm_pkg::SUM_SLOTS];
    int               top;
    int               s;
    longint           c;
    spm_pkg::result_t r;
    fresh_terms.delete();
    for (int k = 0; k < spm_pkg::SUM_SLOTS; k++) begin
      acc[k] = 0;
      hit[k] = 1'b0;
    end
    if (a_len == 0 || b_len == 0) begin
      r.prod_exponent = '0;
      r.prod_coef     = '0;
      r.last_term     = 1'b1;
      r.empty_product = 1'b1;
      r.overflow_seen = drop_seen;
      fresh_terms.push_back(r);
    end else begin
      for (int i = 0; i < a_len; i++) begin
        for (int j = 0; j < b_len; j++) begin
          s = int'(a_exp[i]) + int'(b_exp[j]);
          if (s < spm_pkg::SUM_SLOTS) begin
            acc[s] += longint'(a_coef[i]) * longint'(b_coef[j]);
            hit[s] = 1'b1;
          end
        end
      end
      top = -1;
      for (int k = 0; k < spm_pkg::SUM_SLOTS; k++) begin
        if (hit[k]) top = k;
      end
      for (int k = 0; k < spm_pkg::SUM_SLOTS; k++) begin
        if (hit[k]) begin
          c = acc[k];
          if (c > COEF_HI) c = COEF_HI;
          if (c < COEF_LO) c = COEF_LO;
          r.prod_exponent = k[4:0];
          r.prod_coef     = c[39:0];
          r.last_term     = (k == top);
          r.empty_product = 1'b0;
          r.overflow_seen = drop_seen;
          fresh_terms.push_back(r);
        end
      end
    end
    clear_operands();
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint wanted);
    err_count++;
    if (err_count <= 40)
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, wanted);
  endtask

  function automatic spm_pkg::item_t mk_item(logic [1:0] mode, logic signed [15:0] c,
                                             logic [3:0] e);
    spm_pkg::item_t it;
    it.mode          = mode;
    it.term_coef     = c;
    it.term_exponent = e;
    return it;
  endfunction

  function automatic dir_row_t load_row(logic [1:0] mode, int c, int e, int reps);
    dir_row_t   row;
    logic [31:0] cw;
    logic [31:0] ew;
    cw        = c;
    ew        = e;
    row.beat  = mk_item(mode, cw[15:0], ew[3:0]);
    row.reps  = reps[7:0];
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // A product request; when typed, the single term it must yield is given here.
  function automatic dir_row_t prod_row(bit typed, int e, longint c, bit empty, bit ovf);
    dir_row_t row;
    row                    = load_row(spm_pkg::MODE_PROD, 0, 0, 1);
    row.typed              = typed;
    row.want.prod_exponent = e[4:0];
    row.want.prod_coef     = c[39:0];
    row.want.last_term     = 1'b1;
    row.want.empty_product = empty;
    row.want.overflow_seen = ovf;
    return row;
  endfunction

  function automatic logic signed [15:0] rand_coef();
    logic [31:0] w;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 10)      w = 32'h8000;
    else if (r < 20) w = 32'h7FFF;
    else if (r < 45) w = $urandom_range(0, 6) - 3;
    else             w = $urandom;
    return w[15:0];
  endfunction

  // Small exponents come often so that products pile up on shared slots.
  function automatic logic [3:0] rand_exp();
    logic [31:0] w;
    if ($urandom_range(0, 99) < 30) w = $urandom_range(0, 3);
    else                            w = $urandom_range(0, 15);
    return w[3:0];
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 0;
    if (r < 75) return $urandom_range(1, 5);
    if (r < 93) return $urandom_range(6, 16);
    return $urandom_range(17, 20);
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one beat and hold it until the block takes it.
  task automatic send_beat(input spm_pkg::item_t beat, input bit typed,
                           input spm_pkg::result_t typed_want, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    row_typed  <= typed;
    row_want   <= typed_want;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding product term has arrived.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_terms.size() != 0);
  endtask

  // Result stall: random holds, with a recurring quiet stretch between them.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ((cyc % 700) >= 500) begin
      result_stall <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        result_stall <= 1'b0;
      end else begin
        stall_len    = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        result_stall <= 1'b1;
        stall_left   <= stall_len - 1;
      end
    end
  end

  // Predict on every accepted item beat and check every accepted result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        n_items++;
        case (item.mode)
          spm_pkg::MODE_LOAD_A: take_term(1'b0, item.term_coef, item.term_exponent);
          spm_pkg::MODE_LOAD_B: take_term(1'b1, item.term_coef, item.term_exponent);
          spm_pkg::MODE_PROD: begin
            multiply_operands();
            n_products++;
            if (fresh_terms[0].empty_product) n_empty++;
            if (row_typed) pending_terms.push_back(row_want);
            else foreach (fresh_terms[k]) pending_terms.push_back(fresh_terms[k]);
          end
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        n_results++;
        if (pending_terms.size() == 0) begin
          report_mismatch("unexpected result beat, exponent", result.prod_exponent, -1);
        end else begin
          want = pending_terms.pop_front();
          if (result.prod_exponent !== want.prod_exponent)
            report_mismatch("prod_exponent", result.prod_exponent, want.prod_exponent);
          if (result.prod_coef !== want.prod_coef)
            report_mismatch("prod_coef", $signed(result.prod_coef), $signed(want.prod_coef));
          if (result.last_term !== want.last_term)
            report_mismatch("last_term", result.last_term, want.last_term);
          if (result.empty_product !== want.empty_product)
            report_mismatch("empty_product", result.empty_product, want.empty_product);
          if (result.overflow_seen !== want.overflow_seen)
            report_mismatch("overflow_seen", result.overflow_seen, want.overflow_seen);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d terms outstanding",
               idle_cycles, pending_terms.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int             na;
    int             nb;
    bit             pick_b;
    logic [31:0]    w;
    spm_pkg::item_t beat;

    // Directed table.
    dir_rows.push_back(prod_row(1, 0, 0, 1, 0));                  // empty right after reset
    dir_rows.push_back(load_row(MODE_NONE, -1, 15, 1));           // ignored code
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_A, -32768, 15, 1));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, -32768, 15, 1));
    dir_rows.push_back(prod_row(1, 30, 64'sd1073741824, 0, 0));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_A, 32767, 0, 1));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, -32768, 0, 1));
    dir_rows.push_back(prod_row(1, 0, -64'sd1073709056, 0, 0));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_A, 5, 2, 1));  // only A loaded
    dir_rows.push_back(prod_row(1, 0, 0, 1, 0));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, 5, 2, 1));  // only B loaded
    dir_rows.push_back(prod_row(1, 0, 0, 1, 0));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_A, 7, 3, 17)); // A store overfull
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, 1, 0, 1));
    dir_rows.push_back(prod_row(1, 3, 112, 0, 1));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, -1, 9, 17)); // overfull and empty
    dir_rows.push_back(prod_row(1, 0, 0, 1, 1));
    dir_rows.push_back(prod_row(1, 0, 0, 1, 0));                  // dropped flag cleared
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_A, 1, 0, 1));  // (1+x)(1-x)
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_A, 1, 1, 1));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, 1, 0, 1));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, -1, 1, 1));
    dir_rows.push_back(prod_row(0, 0, 0, 0, 0));                  // zero middle term
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_A, 32767, 15, 16)); // largest accumulation
    dir_rows.push_back(load_row(MODE_NONE, 32767, 15, 1));
    dir_rows.push_back(load_row(spm_pkg::MODE_LOAD_B, 32767, 15, 16));
    dir_rows.push_back(prod_row(1, 30, 64'sd274861129984, 0, 0));

    clear_operands();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      repeat (dir_rows[k].reps)
        send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want, pick_gap());
    end
    wait_drained();

    // Random operand sequences, each closed by a product request.
    while (n_sent < RANDOM_ITEMS) begin
      n_seq++;
      steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // Noise: beats of any code in any order.
        repeat ($urandom_range(1, 4)) begin
          w    = $urandom;
          beat = mk_item(w[1:0], rand_coef(), rand_exp());
          send_beat(beat, 1'b0, '0, pick_gap());
          if (beat.mode != MODE_NONE) n_sent++;
        end
      end else begin
        na = rand_len();
        nb = rand_len();
        while (na + nb > 0) begin
          pick_b = (na == 0) || (nb != 0 && $urandom_range(0, 1) == 1);
          if (pick_b) nb--;
          else        na--;
          beat = mk_item(pick_b ? spm_pkg::MODE_LOAD_B : spm_pkg::MODE_LOAD_A,
                         rand_coef(), rand_exp());
          send_beat(beat, 1'b0, '0, pick_gap());
          n_sent++;
          if ($urandom_range(0, 29) == 0)
            send_beat(mk_item(MODE_NONE, rand_coef(), rand_exp()), 1'b0, '0, pick_gap());
        end
        if ($urandom_range(0, 9) == 0) wait_drained();
        send_beat(mk_item(spm_pkg::MODE_PROD, rand_coef(), rand_exp()), 1'b0, '0,
                  pick_gap());
        n_sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_terms.size() != 0)
      report_mismatch("result beats missing at end, count", pending_terms.size(), 0);

    $display("covered %0d item beats, %0d product requests (%0d empty), %0d result beats",
             n_items, n_products, n_empty, n_results);
    $display("directed extremes, store-full drops and cancellation, then %0d random sequences",
             n_seq);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sparse_polynomial_multiplier.f
src/spm_pkg.sv
src/spm_ctrl.sv
src/spm_datapath.sv
src/sparse_polynomial_multiplier.sv
dv/tb_sparse_polynomial_multiplier.sv
